// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types, constants and CRC helper
// Parser state codes, framing bytes, result record and the byte-wide
// reflected CRC-16 update used by the stuffed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

	// framing bytes
	localparam logic [7:0]  ESC_BYTE  = 8'hAA;
	localparam logic [7:0]  FLAG_BYTE = 8'h01;

	// CRC-16, reflected
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	// configuration
	localparam int          BUF_SIZE_W     = 11;
	localparam logic [10:0] BUF_SIZE_RESET = 11'd80;

	// return codes
	localparam logic signed [10:0] RET_CONSUMED = -11'sd1;
	localparam logic signed [10:0] RET_IGNORED  = 11'sd0;

	// parser state; code 0 is never entered by state_q (prior_q resets to it) but is decoded as "ignore"
	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_WAIT = 2'd1,
		ST_DATA = 2'd2,
		ST_ESC  = 2'd3
	} sfr_state_t;

	// one result beat
	typedef struct packed {
		logic [7:0]         write_data;
		logic [9:0]         write_index;
		logic               write_valid;
		logic signed [10:0] return_code;
	} sfr_result_t;

	// one byte through the CRC, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/stuffed_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16: byte-stuffed frame receiver with CRC-16
// Stream wrapper around the deframing parser: input register, parser
// step, output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received serial byte per beat. m_axis returns exactly
//   one result beat per input beat: the return code (-1 consumed, 0 ignored,
//   positive payload length of a good frame) in tdata, plus the buffer write
//   (index, data) for a stored byte; tuser flags that the write is valid.
//   cfg_we/cfg_wdata set the buffer size; write it only while no beat is in
//   flight.
//   Throughput: one byte per cycle while m_axis_tready is high, set by the parser step
//   (byte compare, state update and the unrolled 8-bit CRC network).
//   Path: a byte accepted into the input register passes the parser step and
//   is captured in the output register, which drives m_axis.
//   Reset: parser waits for escape+flag, count and CRC are zero, buffer size
//   is 80, both pipeline stages are empty.
//   Stall: while m_axis_tready is low the result holds; the input register
//   fills and then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stuffed_frame_receiver_crc16 #(
	parameter int MAX_FRAME = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,     // buffer_size
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [10:0] return_code, [20:11] write_index,
	                                   // [28:21] write_data, [31:29] zero
	output logic [0:0]  m_axis_tuser   // [0] write_valid
);
	import sfr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	sfr_result_t out_q;
	sfr_result_t result;
	logic        advance;

	// input stage moves on when the output register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	sfr_parser #(
		.MAX_FRAME (MAX_FRAME)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.rx_byte   (byte_s1),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.write_data, out_q.write_index,
	                        out_q.return_code};
	assign m_axis_tuser  = out_q.write_valid;

	// the input stage never overwrites an unconsumed byte
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && byte_s1 == $past(byte_s1))
		else $error("input stage lost a byte");

	// a stalled result is never replaced
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !advance)
		else $error("result overwritten while stalled");

	// results leave only when the parser has stepped
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result valid without a parser step");

endmodule

// ===== hw/rtl/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// sfr_parser: deframing state machine and CRC
// Holds the parser state, byte count, running CRC and the buffer size
// register; turns one byte per step into one result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_parser #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [10:0]              cfg_wdata,
	input  logic                     step,
	input  logic [7:0]               rx_byte,
	output sfr_pkg::sfr_result_t     result
);
	import sfr_pkg::*;

	// count must hold MAX_FRAME and be wide enough for index and length
	localparam int FW = $clog2(MAX_FRAME + 1);
	localparam int CW = (FW > BUF_SIZE_W) ? FW : BUF_SIZE_W;

	logic [10:0]   buf_size_q;
	sfr_state_t    state_q, state_d;
	sfr_state_t    prior_q, prior_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   crc_q, crc_d;
	logic [CW-1:0] cap;
	logic [CW-1:0] buf_ext;
	logic [CW-1:0] len;
	logic [15:0]   crc_upd;

	// effective capacity
	assign buf_ext = CW'(buf_size_q);
	assign cap     = (buf_ext < CW'(MAX_FRAME)) ? buf_ext : CW'(MAX_FRAME);
	assign crc_upd = crc_byte(crc_q, rx_byte);
	assign len     = count_q - CW'(2);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= BUF_SIZE_RESET;
		end else if (cfg_we) begin
			buf_size_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		prior_d = prior_q;
		count_d = count_q;
		crc_d   = crc_q;
		unique case (state_q)
			ST_WAIT: begin
				if (rx_byte == ESC_BYTE) begin
					prior_d = ST_WAIT;
					state_d = ST_ESC;
				end
			end
			ST_DATA: begin
				if (rx_byte != ESC_BYTE) begin
					count_d = count_q + CW'(1);
					crc_d   = crc_upd;
				end else begin
					prior_d = ST_DATA;
					state_d = ST_ESC;
				end
			end
			ST_ESC: begin
				if (rx_byte == FLAG_BYTE) begin
					// empty count opens a frame; good close goes back to waiting;
					// bad close stays in escape
					if (count_q == '0) begin
						state_d = ST_DATA;
					end else if (crc_q == '0 && count_q > CW'(1)) begin
						state_d = ST_WAIT;
					end
					count_d = '0;
					crc_d   = CRC_INIT;
				end else if (rx_byte == ESC_BYTE && prior_q == ST_DATA) begin
					// doubled escape inside data
					count_d = count_q + CW'(1);
					crc_d   = crc_upd;
					state_d = ST_DATA;
				end else begin
					state_d = ST_WAIT;
				end
			end
			default: begin
			end
		endcase
		// full buffer drops the frame
		if (count_d >= cap) begin
			state_d = ST_WAIT;
		end
	end

	// result
	always_comb begin
		result             = '0;
		result.return_code = RET_IGNORED;
		unique case (state_q)
			ST_WAIT: begin
				if (rx_byte == ESC_BYTE) begin
					result.return_code = RET_CONSUMED;
				end
			end
			ST_DATA: begin
				result.return_code = RET_CONSUMED;
				if (rx_byte != ESC_BYTE) begin
					result.write_valid = 1'b1;
					result.write_index = count_q[9:0];
					result.write_data  = rx_byte;
				end
			end
			ST_ESC: begin
				result.return_code = RET_CONSUMED;
				if (rx_byte == FLAG_BYTE) begin
					if (count_q != '0 && crc_q == '0 && count_q > CW'(1)) begin
						result.return_code = len[10:0];
					end
				end else if (rx_byte == ESC_BYTE && prior_q == ST_DATA) begin
					result.write_valid = 1'b1;
					result.write_index = count_q[9:0];
					result.write_data  = ESC_BYTE;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
			prior_q <= ST_NONE;
			count_q <= '0;
			crc_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			prior_q <= prior_d;
			count_q <= count_d;
			crc_q   <= crc_d;
		end
	end

	// a stored byte always advances the count by one
	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.write_valid |=> count_q == $past(count_q) + CW'(1))
		else $error("stored byte did not advance count");

	// stored bytes are always reported as consumed
	a_write_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		result.write_valid |-> result.return_code == RET_CONSUMED)
		else $error("stored byte without consumed code");

	// escape is only entered from waiting or data
	a_esc_prior: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ESC |-> (prior_q == ST_WAIT || prior_q == ST_DATA))
		else $error("escape state with bad prior state");

	// a reported frame length leaves the parser waiting with a fresh CRC
	a_good_close: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.return_code > 11'sd0 |=> state_q == ST_WAIT && crc_q == CRC_INIT)
		else $error("good frame close left parser in wrong state");

endmodule
